// File: src/rbc_pkg.sv
`timescale 1ns / 1ps

package rbc_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int MAX_OUT_DIGITS = 32;
	localparam int BASE_W         = 6;
	localparam int CHAR_W         = 8;
	localparam int CNT_W          = $clog2(MAX_OUT_DIGITS + 1);
	localparam int ADDR_W         = $clog2(MAX_OUT_DIGITS);
	localparam int STEP_W         = $clog2(VALUE_BITS);
	localparam int CFG_ADDR_W     = 2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] LETTER_OFS   = 8'd55;
	localparam logic [BASE_W-1:0] DEC_RADIX    = 6'd10;
	localparam logic [BASE_W-1:0] MAX_RADIX    = 6'd36;
	localparam logic [BASE_W-1:0] MIN_IN_RADIX = 6'd1;
	localparam logic [BASE_W-1:0] MIN_OUT_RADIX = 6'd2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_START_BASE = 2'd0,
		REG_END_BASE   = 2'd1
	} rbc_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_READ,
		ST_LOAD,
		ST_SEND
	} rbc_state_t;

	// divider command and status
	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [BASE_W-1:0]     divisor;
	} rbc_div_cmd_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [BASE_W-1:0]     remainder;
	} rbc_div_res_t;

	// digit buffer and output register control
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BASE_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              load_digit;
		logic              load_flag;
		logic              last;
		logic              empty;
		logic              error;
	} rbc_emit_ctrl_t;

	function automatic logic [CHAR_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = c;
		if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
			d = c - LETTER_OFS;
		end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
			d = c - CHAR_ZERO;
		end
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_RADIX) begin
			c = CHAR_W'(d) + CHAR_ZERO;
		end else begin
			c = CHAR_W'(d) + LETTER_OFS;
		end
		return c;
	endfunction

endpackage

// File: src/rbc_accum.sv
`timescale 1ns / 1ps

module rbc_accum import rbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  final_char,
	input  logic [CHAR_W-1:0]     digit_char,
	input  logic [BASE_W-1:0]     start_base,
	output logic [VALUE_BITS-1:0] sum_value
);

	logic [VALUE_BITS-1:0]        acc_q;
	logic [VALUE_BITS+BASE_W-1:0] prod;

	// value * radix + digit, wrapping
	assign prod      = {{BASE_W{1'b0}}, acc_q} * {{VALUE_BITS{1'b0}}, start_base};
	assign sum_value = prod[VALUE_BITS-1:0] + VALUE_BITS'(char_to_digit(digit_char));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= final_char ? '0 : sum_value;
		end
	end

endmodule

// File: src/rbc_divider.sv
`timescale 1ns / 1ps

module rbc_divider import rbc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rbc_div_cmd_t cmd,
	output rbc_div_res_t res
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [BASE_W-1:0]     rem_q;
	logic [BASE_W:0]       trial;
	logic [BASE_W:0]       diff;
	logic                  fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, cmd.divisor};
	assign diff  = trial - {1'b0, cmd.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
		end
	end

	assign res.busy      = busy_q;
	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule

// File: src/rbc_emitter.sv
`timescale 1ns / 1ps

module rbc_emitter import rbc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  rbc_emit_ctrl_t ctrl,
	input  logic           m_tready,
	output logic           m_tvalid,
	output logic [7:0]     m_tdata,  // out_char
	output logic           m_tlast,  // last_out
	output logic [1:0]     m_tuser   // empty_result, base_error
);

	logic [BASE_W-1:0] digit_mem [MAX_OUT_DIGITS];
	logic [BASE_W-1:0] rd_data_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              empty_q;
	logic              error_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			digit_mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= digit_mem[ctrl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load_digit || ctrl.load_flag) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_digit) begin
			char_q  <= digit_to_char(rd_data_q);
			last_q  <= ctrl.last;
			empty_q <= 1'b0;
			error_q <= 1'b0;
		end else if (ctrl.load_flag) begin
			char_q  <= '0;
			last_q  <= 1'b1;
			empty_q <= ctrl.empty;
			error_q <= ctrl.error;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;
	assign m_tuser  = {error_q, empty_q};

endmodule

// File: src/radix_base_converter_top.sv
`timescale 1ns / 1ps

// radix base converter: takes the ascii digits of a number most significant first, one item per
// character with tlast on the final one, and returns the number in another radix, most
// significant digit first. letters 'A'-'Z' count 10-35, '0'-'9' count 0-9, any other code counts
// as its own value; digits fold into a 32-bit wrapping value as value*start_base+digit. on the
// final character a bad radix (start_base 0, end_base below 2 or above 36) gives one item with
// base_error set, and with a good radix a value that is zero or has bit 31 set gives one item
// with empty_result set. otherwise the value goes through the restoring divider, one quotient
// bit per cycle. after the final character each output digit goes through the divider loop
// (start, bit steps, write-back into the digit buffer), then each result item goes through
// buffer read, output load and handshake, and waits while m_tready stays low. a flagged result
// goes through decide and handshake after the final character. s_tready is low from the final
// character until the last result item has been taken.
module radix_base_converter_top import rbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [BASE_W-1:0]     cfg_wdata,
	// character input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // digit_char
	input  logic                  s_tlast,   // final_char
	// converted digits
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // out_char
	output logic                  m_tlast,   // last_out
	output logic [1:0]            m_tuser    // bit 0 empty_result, bit 1 base_error
);

	rbc_state_t            state_q, state_next;
	logic [BASE_W-1:0]     start_base_q;
	logic [BASE_W-1:0]     end_base_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  err_q;
	logic                  empty_q;
	logic                  in_accept;
	logic                  out_accept;
	logic [VALUE_BITS-1:0] sum_value;
	logic                  bad_base;
	logic                  not_positive;
	logic                  div_stop;
	rbc_div_cmd_t          div_cmd;
	rbc_div_res_t          div_res;
	rbc_emit_ctrl_t        emit_ctrl;

	assign in_accept  = s_tvalid && s_tready;
	assign out_accept = m_tvalid && m_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_base_q <= DEC_RADIX;
			end_base_q   <= DEC_RADIX;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_START_BASE: start_base_q <= cfg_wdata;
				REG_END_BASE:   end_base_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rbc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.final_char (s_tlast),
		.digit_char (s_tdata),
		.start_base (start_base_q),
		.sum_value  (sum_value)
	);

	assign bad_base = (start_base_q < MIN_IN_RADIX) || (end_base_q < MIN_OUT_RADIX)
		|| (end_base_q > MAX_RADIX);
	assign not_positive = (sum_value == '0) || sum_value[VALUE_BITS-1];

	// stop once the quotient runs out or the buffer is full
	assign div_stop = (div_res.quotient == '0) || (count_q == CNT_W'(MAX_OUT_DIGITS - 1));

	rbc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	rbc_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (emit_ctrl),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && s_tlast) begin
					state_next = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_next = (err_q || empty_q) ? ST_SEND : ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_next = div_stop ? ST_READ : ST_DECIDE;
				end
			end
			ST_READ: state_next = ST_LOAD;
			ST_LOAD: state_next = ST_SEND;
			ST_SEND: begin
				if (out_accept) begin
					state_next = m_tlast ? ST_IDLE : ST_READ;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready         = 1'b0;
		div_cmd.start    = 1'b0;
		div_cmd.dividend = value_q;
		div_cmd.divisor  = end_base_q;
		emit_ctrl     = '0;
		emit_ctrl.wr_addr = count_q[ADDR_W-1:0];
		emit_ctrl.wr_data = div_res.remainder;
		emit_ctrl.rd_addr = rd_idx_q[ADDR_W-1:0];
		emit_ctrl.last    = (rd_idx_q == '0);
		emit_ctrl.empty   = empty_q && !err_q;
		emit_ctrl.error   = err_q;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_DECIDE: begin
				if (err_q || empty_q) begin
					emit_ctrl.load_flag = 1'b1;
				end else begin
					div_cmd.start = 1'b1;
				end
			end
			ST_DIV:    emit_ctrl.wr_en = div_res.done;
			ST_READ:   emit_ctrl.rd_en = 1'b1;
			ST_LOAD:   emit_ctrl.load_digit = 1'b1;
			ST_SEND:   ;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			err_q    <= 1'b0;
			empty_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_IDLE && in_accept && s_tlast) begin
				err_q   <= bad_base;
				empty_q <= not_positive;
				count_q <= '0;
			end
			if (state_q == ST_DIV && div_res.done) begin
				count_q  <= count_q + 1'b1;
				rd_idx_q <= count_q;
			end
			if (state_q == ST_SEND && out_accept && !m_tlast) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	// working value for the divider loop
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_accept && s_tlast) begin
			value_q <= sum_value;
		end else if (state_q == ST_DIV && div_res.done) begin
			value_q <= div_res.quotient;
		end
	end

	// no new character is taken while a result is pending
	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a result item is pending");

	// a flagged result always closes the run
	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != 2'b00) |-> m_tlast)
		else $error("flagged result without last");

	// divider only runs while the input side is closed
	a_div_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.busy |-> !s_tready)
		else $error("divider busy while input ready");

	// after the last item of a run the block is ready again
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block not ready after last result item");

endmodule
